// File: sv/u8d_pkg.sv
// Shared constants, types and the lead byte classifier of the UTF-8 decoder.
package u8d_pkg;

	localparam int MaxSeq    = 6;
	localparam int CntW      = $clog2(MaxSeq + 1);
	localparam int IdxW      = $clog2(MaxSeq);
	localparam int CpW       = 31;
	localparam int FifoDepth = 4;
	localparam int PtrW      = $clog2(FifoDepth);
	localparam int FillW     = $clog2(FifoDepth + 1);

	localparam logic [7:0] LeadTwo   = 8'hC0;
	localparam logic [7:0] LeadThree = 8'hE0;
	localparam logic [7:0] LeadFour  = 8'hF0;
	localparam logic [7:0] LeadFive  = 8'hF8;
	localparam logic [7:0] LeadSix   = 8'hFC;
	localparam logic [7:0] LeadMask  = 8'h7F;
	localparam logic [7:0] Bom0      = 8'hEF;
	localparam logic [7:0] Bom1      = 8'hBB;
	localparam logic [7:0] Bom2      = 8'hBF;
	localparam logic [CntW-1:0] BomLen = CntW'(3);

	typedef struct packed {
		logic [7:0]      data;
		logic [CntW-1:0] len;
	} ent_t;

	localparam int EntW = $bits(ent_t);

	typedef ent_t [MaxSeq-1:0] win_t;

	typedef struct packed {
		ent_t ent;
		logic last;
	} item_t;

	typedef struct packed {
		logic [CpW-1:0] cp;
		logic           raw;
		logic           final_char;
		logic           run_last;
	} res_t;

	// Sequence length opened by a byte, or zero when it opens none.
	function automatic logic [CntW-1:0] seq_len(input logic [7:0] b);
		int len;
		len = 0;
		if (b >= LeadSix) len = 6;
		else if (b >= LeadFive) len = 5;
		else if (b >= LeadFour) len = 4;
		else if (b >= LeadThree) len = 3;
		else if (b >= LeadTwo) len = 2;
		if (len > MaxSeq) len = 0;
		return CntW'(len);
	endfunction

endpackage

// File: sv/u8d_front.sv
// Input side: takes bytes, classifies their sequence length and queues them.
module u8d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // data_byte[7:0]
	input  logic                 s_tlast,   // message_end
	output logic                 q_valid,
	output u8d_pkg::item_t       q_item,
	input  logic                 q_pop
);

	u8d_pkg::item_t                mem_q [u8d_pkg::FifoDepth];
	logic [u8d_pkg::PtrW-1:0]      wr_ptr_q;
	logic [u8d_pkg::PtrW-1:0]      rd_ptr_q;
	logic [u8d_pkg::FillW-1:0]     fill_q;
	logic                          push;
	logic                          pop;
	u8d_pkg::item_t                new_item;

	assign s_tready = fill_q != u8d_pkg::FillW'(u8d_pkg::FifoDepth);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = fill_q != '0;
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_comb begin
		new_item.ent.data = s_tdata;
		new_item.ent.len  = u8d_pkg::seq_len(s_tdata);
		new_item.last     = s_tlast;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + u8d_pkg::PtrW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + u8d_pkg::PtrW'(1);
			if (push && !pop) fill_q <= fill_q + u8d_pkg::FillW'(1);
			else if (pop && !push) fill_q <= fill_q - u8d_pkg::FillW'(1);
		end
	end

endmodule

// File: sv/u8d_back.sv
// Decode engine: scans a window of held bytes, rescans failed sequences, drives results.
module u8d_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  u8d_pkg::item_t  in_item,
	output logic            in_pop,
	output logic            out_valid,
	output u8d_pkg::res_t   out_res,
	input  logic            out_ready
);

	u8d_pkg::win_t                 buf_q;
	logic [u8d_pkg::CntW-1:0]      pcnt_q;
	logic [u8d_pkg::CntW-1:0]      tot_q;
	logic [u8d_pkg::CntW-1:0]      exp_q;
	logic [u8d_pkg::CpW-1:0]       acc_q;
	logic                          at_start_q;
	logic                          busy_q;
	logic                          end_q;
	logic                          h_valid_q;
	logic [u8d_pkg::CpW-1:0]       h_cp_q;
	logic                          h_raw_q;
	logic                          o_valid_q;
	u8d_pkg::res_t                 o_res_q;

	u8d_pkg::win_t                 vb;
	u8d_pkg::win_t                 nbuf;
	u8d_pkg::ent_t                 cur;
	logic                          adv;
	logic                          has_buf;
	logic                          flush;
	logic                          fin;
	logic                          take;
	logic                          scan;
	logic                          start_eff;
	logic                          emit;
	logic                          move;
	logic                          bom;
	logic [u8d_pkg::CpW-1:0]       acc_n;
	logic [u8d_pkg::CpW-1:0]       r_cp;
	logic                          r_raw;
	logic [u8d_pkg::CntW-1:0]      shamt;
	logic [u8d_pkg::CntW-1:0]      n_pcnt;
	logic [u8d_pkg::CntW-1:0]      n_tot;
	logic [u8d_pkg::CntW-1:0]      n_exp;
	logic [u8d_pkg::CpW-1:0]       n_acc;
	logic                          n_start;

	assign adv       = !o_valid_q || out_ready;
	assign out_valid = o_valid_q;
	assign out_res   = o_res_q;

	always_comb begin
		has_buf   = pcnt_q < tot_q;
		flush     = busy_q && end_q && (pcnt_q != '0) && !has_buf;
		fin       = busy_q && !has_buf && !flush;
		take      = !has_buf && !flush && in_valid;
		scan      = has_buf || take;
		start_eff = at_start_q || (fin && end_q);
		in_pop    = adv && take;

		vb = buf_q;
		if (take) vb[pcnt_q[u8d_pkg::IdxW-1:0]] = in_item.ent;
		cur   = vb[pcnt_q[u8d_pkg::IdxW-1:0]];
		acc_n = {acc_q[u8d_pkg::CpW-7:0], cur.data[5:0]};
		bom   = start_eff && (exp_q == u8d_pkg::BomLen) && (vb[0].data == u8d_pkg::Bom0) &&
			(vb[1].data == u8d_pkg::Bom1) && (cur.data == u8d_pkg::Bom2);

		emit    = 1'b0;
		r_cp    = {{(u8d_pkg::CpW-8){1'b0}}, vb[0].data};
		r_raw   = 1'b1;
		shamt   = '0;
		n_pcnt  = pcnt_q;
		n_exp   = exp_q;
		n_acc   = acc_q;
		n_start = start_eff;

		if (flush) begin
			emit    = 1'b1;
			shamt   = u8d_pkg::CntW'(1);
			n_pcnt  = '0;
			n_exp   = '0;
			n_start = 1'b0;
		end else if (scan) begin
			if (pcnt_q == '0) begin
				if (cur.len == '0) begin
					emit    = 1'b1;
					r_cp    = {{(u8d_pkg::CpW-8){1'b0}}, cur.data};
					r_raw   = cur.data[7];
					shamt   = u8d_pkg::CntW'(1);
					n_start = 1'b0;
				end else begin
					n_pcnt = u8d_pkg::CntW'(1);
					n_exp  = cur.len;
					n_acc  = {{(u8d_pkg::CpW-8){1'b0}}, cur.data & (u8d_pkg::LeadMask >> cur.len)};
				end
			end else if (cur.data[7]) begin
				if (pcnt_q + u8d_pkg::CntW'(1) == exp_q) begin
					emit    = !bom;
					r_cp    = acc_n;
					r_raw   = 1'b0;
					shamt   = exp_q;
					n_pcnt  = '0;
					n_exp   = '0;
					n_start = 1'b0;
				end else begin
					n_pcnt = pcnt_q + u8d_pkg::CntW'(1);
					n_acc  = acc_n;
				end
			end else begin
				emit    = 1'b1;
				shamt   = u8d_pkg::CntW'(1);
				n_pcnt  = '0;
				n_exp   = '0;
				n_start = 1'b0;
			end
		end

		n_tot = (take ? tot_q + u8d_pkg::CntW'(1) : tot_q) - shamt;
		nbuf  = u8d_pkg::win_t'(vb >> (shamt * u8d_pkg::EntW));
		move  = h_valid_q && (emit || fin);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			buf_q <= nbuf;
			acc_q <= n_acc;
			if (emit) begin
				h_cp_q  <= r_cp;
				h_raw_q <= r_raw;
			end
			if (move) begin
				o_res_q.cp         <= h_cp_q;
				o_res_q.raw        <= h_raw_q;
				o_res_q.run_last   <= fin;
				o_res_q.final_char <= fin && end_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q     <= '0;
			tot_q      <= '0;
			exp_q      <= '0;
			at_start_q <= 1'b1;
			busy_q     <= 1'b0;
			end_q      <= 1'b0;
			h_valid_q  <= 1'b0;
			o_valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				pcnt_q     <= n_pcnt;
				tot_q      <= n_tot;
				exp_q      <= n_exp;
				at_start_q <= n_start;
				if (take) begin
					busy_q <= 1'b1;
					end_q  <= in_item.last;
				end else if (fin) begin
					busy_q <= 1'b0;
				end
				if (emit) h_valid_q <= 1'b1;
				else if (fin) h_valid_q <= 1'b0;
			end
			if (adv && move) o_valid_q <= 1'b1;
			else if (out_ready) o_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/utf8_lenient_decoder.sv
// Top level of the lenient extended UTF-8 decoder: input queue and decode engine.
// Bytes enter through a four-entry queue, so the input keeps flowing while a result waits.
// The decode engine performs one action per cycle unless the output stalls it: scanning
// one byte, or emitting a lead byte raw when a sequence fails or a message ends. ASCII
// bytes and complete sequences therefore go through at one byte per cycle unless the
// output stalls; after a failed sequence the bytes behind its lead are scanned again, and
// at message end the lead byte of an unfinished sequence is emitted raw and the bytes
// behind it scanned again. Each result is held until the engine produces the next one or
// finishes its byte, since only then is it known whether it is the last one caused by
// that byte, and then passes through the output register. The engine pauses while the
// output register holds an item that has not been taken.
module utf8_lenient_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tlast,   // message_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // code_point[30:0], zero[31]
	output logic [1:0]  m_tuser,   // raw_byte[0], run_last[1]
	output logic        m_tlast    // final_char
);

	logic           q_valid;
	logic           q_pop;
	u8d_pkg::item_t q_item;
	u8d_pkg::res_t  res;

	u8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.in_pop    (q_pop),
		.out_valid (m_tvalid),
		.out_res   (res),
		.out_ready (m_tready)
	);

	assign m_tdata = {1'b0, res.cp};
	assign m_tuser = {res.run_last, res.raw};
	assign m_tlast = res.final_char;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench of the lenient extended UTF-8 decoder with a byte-level predictor.
module testbench;

	localparam int MaxRes        = 6;
	localparam int IdlePct       = 16;
	localparam int RandItems     = 235;
	localparam int WatchdogLimit = 1000;
	localparam int TailCycles    = 40;

	typedef logic [7:0] u8_t;

	typedef struct packed {
		u8_t  b;
		logic eom;
	} byte_in_t;

	typedef struct {
		u8_t                     b;
		logic                    eom;
		logic                    typed;
		logic [u8d_pkg::CpW-1:0] cp;
		logic                    raw;
	} row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	utf8_lenient_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	u8_t  hold_buf [6];
	int   hold_cnt  = 0;
	int   seq_want  = 0;
	logic msg_start = 1'b1;

	u8_t           scan_q[$];
	u8d_pkg::res_t step_chars[$];
	u8d_pkg::res_t chars_due[$];

	int   errors       = 0;
	int   stall_cycles = 0;
	logic quiet        = 1'b0;

	row_t dir_tab [25];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int lead_len(input u8_t b);
		int len;
		len = 0;
		if (b >= u8d_pkg::LeadSix) len = 6;
		else if (b >= u8d_pkg::LeadFive) len = 5;
		else if (b >= u8d_pkg::LeadFour) len = 4;
		else if (b >= u8d_pkg::LeadThree) len = 3;
		else if (b >= u8d_pkg::LeadTwo) len = 2;
		if (len > u8d_pkg::MaxSeq) len = 0;
		return len;
	endfunction

	function automatic void put_char(input logic [u8d_pkg::CpW-1:0] cp, input logic raw);
		u8d_pkg::res_t r;
		if (step_chars.size() < MaxRes) begin
			r.cp = cp;
			r.raw = raw;
			r.final_char = 1'b0;
			r.run_last = 1'b0;
			step_chars.push_back(r);
		end
	endfunction

	function automatic void scan_all();
		u8_t                     b;
		logic [u8d_pkg::CpW-1:0] v;
		while (scan_q.size() > 0) begin
			b = scan_q.pop_front();
			if (hold_cnt == 0) begin
				if (b < 8'h80) begin
					put_char(u8d_pkg::CpW'(b), 1'b0);
					msg_start = 1'b0;
				end else if (lead_len(b) == 0) begin
					put_char(u8d_pkg::CpW'(b), 1'b1);
					msg_start = 1'b0;
				end else begin
					hold_buf[0] = b;
					hold_cnt = 1;
					seq_want = lead_len(b);
				end
			end else if (b[7]) begin
				if (hold_cnt < 6) begin
					hold_buf[hold_cnt] = b;
					hold_cnt++;
				end
				if (hold_cnt >= seq_want) begin
					v = u8d_pkg::CpW'(hold_buf[0] & (8'h7F >> seq_want));
					for (int k = 1; k < seq_want && k < 6; k++)
						v = (v << 6) | u8d_pkg::CpW'(hold_buf[k][5:0]);
					if (!(msg_start && seq_want == 3 && hold_buf[0] == u8d_pkg::Bom0 &&
					      hold_buf[1] == u8d_pkg::Bom1 && hold_buf[2] == u8d_pkg::Bom2))
						put_char(v, 1'b0);
					msg_start = 1'b0;
					hold_cnt = 0;
					seq_want = 0;
				end
			end else begin
				put_char(u8d_pkg::CpW'(hold_buf[0]), 1'b1);
				msg_start = 1'b0;
				scan_q.push_front(b);
				for (int k = hold_cnt - 1; k >= 1; k--) scan_q.push_front(hold_buf[k]);
				hold_cnt = 0;
				seq_want = 0;
			end
		end
	endfunction

	// Leaves the characters caused by one input byte in step_chars.
	function automatic void decode_byte(input u8_t b, input logic eom);
		logic flushing;
		step_chars.delete();
		scan_q.delete();
		scan_q.push_back(b);
		flushing = 1'b1;
		while (flushing) begin
			scan_all();
			if (eom && hold_cnt > 0) begin
				put_char(u8d_pkg::CpW'(hold_buf[0]), 1'b1);
				msg_start = 1'b0;
				for (int k = 1; k < hold_cnt && k < 6; k++) scan_q.push_back(hold_buf[k]);
				hold_cnt = 0;
				seq_want = 0;
			end else begin
				flushing = 1'b0;
			end
		end
		if (step_chars.size() > 0) begin
			step_chars[step_chars.size() - 1].run_last = 1'b1;
			if (eom) step_chars[step_chars.size() - 1].final_char = 1'b1;
		end
		if (eom) begin
			hold_cnt = 0;
			seq_want = 0;
			msg_start = 1'b1;
		end
	endfunction

	task automatic send_byte(input u8_t b, input logic eom);
		while (!quiet && $urandom_range(0, 99) < IdlePct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eom;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_predicted(input u8_t b, input logic eom);
		send_byte(b, eom);
		decode_byte(b, eom);
		foreach (step_chars[i]) chars_due.push_back(step_chars[i]);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chars_due.size() != 0) @(posedge clk);
	endtask

	task automatic make_chunk(ref byte_in_t chunk[$]);
		int       kind;
		int       len;
		int       cut;
		byte_in_t bi;
		u8_t      lo [5];
		u8_t      hi [5];
		lo = '{u8d_pkg::LeadTwo, u8d_pkg::LeadThree, u8d_pkg::LeadFour,
		       u8d_pkg::LeadFive, u8d_pkg::LeadSix};
		hi = '{8'hDF, 8'hEF, 8'hF7, 8'hFB, 8'hFF};
		chunk.delete();
		bi.eom = 1'b0;
		kind = $urandom_range(0, 9);
		len = $urandom_range(2, 6);
		cut = (kind == 6 || kind == 7) ? $urandom_range(1, len - 1) : len;
		if (kind <= 2) begin
			repeat ($urandom_range(1, 3)) begin
				bi.b = u8_t'($urandom_range(0, 127));
				chunk.push_back(bi);
			end
		end else if (kind <= 7) begin
			bi.b = u8_t'($urandom_range(lo[len - 2], hi[len - 2]));
			chunk.push_back(bi);
			for (int k = 1; k < cut; k++) begin
				if ($urandom_range(0, 7) == 0) bi.b = u8_t'($urandom_range(128, 255));
				else bi.b = u8_t'($urandom_range(128, 191));
				chunk.push_back(bi);
			end
			if (kind == 6) begin
				bi.b = u8_t'($urandom_range(0, 127));
				chunk.push_back(bi);
			end
			if (kind == 7) chunk[chunk.size() - 1].eom = 1'b1;
		end else if (kind == 8) begin
			bi.b = u8d_pkg::Bom0;
			chunk.push_back(bi);
			bi.b = u8d_pkg::Bom1;
			chunk.push_back(bi);
			bi.b = u8d_pkg::Bom2;
			chunk.push_back(bi);
		end else begin
			repeat ($urandom_range(1, 3)) begin
				bi.b = u8_t'($urandom_range(0, 255));
				chunk.push_back(bi);
			end
		end
		if ($urandom_range(0, 7) == 0) chunk[chunk.size() - 1].eom = 1'b1;
	endtask

	function automatic void check_char();
		u8d_pkg::res_t want;
		if (chars_due.size() == 0) begin
			if (errors < 10)
				$display("unexpected item: cp=%h raw=%b run_last=%b final=%b",
				         m_tdata, m_tuser[0], m_tuser[1], m_tlast);
			errors++;
		end else begin
			want = chars_due.pop_front();
			if (m_tdata != {1'b0, want.cp} || m_tuser[0] != want.raw ||
			    m_tuser[1] != want.run_last || m_tlast != want.final_char) begin
				if (errors < 10)
					$display("mismatch: cp=%h/%h raw=%b/%b run_last=%b/%b final=%b/%b",
					         {1'b0, want.cp}, m_tdata, want.raw, m_tuser[0],
					         want.run_last, m_tuser[1], want.final_char, m_tlast);
				errors++;
			end
		end
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) check_char();
		m_tready <= quiet || ($urandom_range(0, 99) >= IdlePct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= WatchdogLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		byte_in_t      chunk[$];
		u8d_pkg::res_t typed_char;
		int            sent;
		dir_tab = '{
			'{u8d_pkg::Bom0, 1'b0, 1'b0, 31'h0, 1'b0},
			'{u8d_pkg::Bom1, 1'b0, 1'b0, 31'h0, 1'b0},
			'{u8d_pkg::Bom2, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'h41, 1'b0, 1'b1, 31'h41, 1'b0},
			'{8'h00, 1'b0, 1'b1, 31'h0, 1'b0},
			'{8'h7F, 1'b0, 1'b1, 31'h7F, 1'b0},
			'{8'h80, 1'b0, 1'b1, 31'h80, 1'b1},
			'{8'hC3, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hA9, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hFF, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hBF, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hBF, 1'b0, 1'b1, 31'h7FFFFFFF, 1'b0},
			'{8'hE2, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'h82, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'h41, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'hF8, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'h88, 1'b0, 1'b0, 31'h0, 1'b0},
			'{8'h80, 1'b1, 1'b0, 31'h0, 1'b0},
			'{u8d_pkg::Bom0, 1'b0, 1'b0, 31'h0, 1'b0},
			'{u8d_pkg::Bom1, 1'b0, 1'b0, 31'h0, 1'b0},
			'{u8d_pkg::Bom2, 1'b1, 1'b0, 31'h0, 1'b0},
			'{8'h41, 1'b1, 1'b1, 31'h41, 1'b0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (!dir_tab[i].typed) begin
				send_predicted(dir_tab[i].b, dir_tab[i].eom);
			end else begin
				send_byte(dir_tab[i].b, dir_tab[i].eom);
				decode_byte(dir_tab[i].b, dir_tab[i].eom);
				typed_char.cp = dir_tab[i].cp;
				typed_char.raw = dir_tab[i].raw;
				typed_char.final_char = dir_tab[i].eom;
				typed_char.run_last = 1'b1;
				chars_due.push_back(typed_char);
			end
		end
		drain();

		sent = 0;
		while (sent < RandItems) begin
			make_chunk(chunk);
			foreach (chunk[i]) begin
				quiet = (sent >= 120 && sent < 180);
				send_predicted(chunk[i].b, chunk[i].eom);
				sent++;
			end
			if ($urandom_range(0, 29) == 0) drain();
		end
		quiet = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chars_due.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (errors == 0 && chars_due.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
